// ===== design/radix_integer_to_ascii_core_macros.svh =====
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_core_macros
// assertion macros shared by the integer to ascii block
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TO_ASCII_CORE_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off while reset is asserted
`define RITOA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while reset is asserted
`define RITOA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ritoa_pkg.sv =====
// ----------------------------------------------------------------------------
// ritoa_pkg
// shared constants, command/status types and the digit character lookup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ritoa_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = 6;
	localparam int CNT_W       = 7;
	localparam int DIV_STEP    = 8;

	localparam logic [4:0] RADIX_MIN = 5'd2;
	localparam logic [4:0] RADIX_MAX = 5'd16;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_LOWER = 8'h61;
	localparam logic [7:0] CHAR_UPPER = 8'h41;

	typedef struct packed {
		logic load;
		logic div;
		logic wr_digit;
		logic rd;
		logic emit;
	} ritoa_cmd_t;

	typedef struct packed {
		logic quot_zero;
		logic store_full;
		logic last_one;
	} ritoa_sts_t;

	function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic lower);
		logic [7:0] base;
		if (d < 4'd10) begin
			digit_ascii = CHAR_ZERO + {4'd0, d};
		end else begin
			base = lower ? CHAR_LOWER : CHAR_UPPER;
			digit_ascii = base + {4'd0, d} - 8'd10;
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/ritoa_dp.sv =====
// ----------------------------------------------------------------------------
// ritoa_dp
// datapath: magnitude register, radix divider slice, digit store, output regs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ritoa_dp
	import ritoa_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ritoa_cmd_t  cmd,
	output ritoa_sts_t       sts,
	input  wire logic [63:0] value,
	input  wire logic [4:0]  radix,
	input  wire logic        unsigned_mode,
	input  wire logic        lowercase,
	output logic [7:0]       digit_char,
	output logic             negative,
	output logic             last_digit
);

	localparam int CHUNKS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int MAG_W  = CHUNKS * DIV_STEP;

	logic [MAG_W-1:0]      mag_q;
	logic [3:0]            rem_q;
	logic [4:0]            radix_q;
	logic                  lower_q;
	logic                  neg_q;
	logic [CNT_W-1:0]      count_q;
	logic [3:0]            rd_q;
	logic [3:0]            digit_store_q [STORE_DEPTH];

	logic [VALUE_BITS-1:0] v_in;
	logic                  v_neg;
	logic [VALUE_BITS-1:0] v_mag;
	logic [4:0]            radix_cl;
	logic [DIV_STEP-1:0]   q_bits;
	logic [3:0]            rem_next;
	logic [ADDR_W-1:0]     rd_addr;

	assign v_in  = value[VALUE_BITS-1:0];
	assign v_neg = !unsigned_mode && v_in[VALUE_BITS-1];
	assign v_mag = v_neg ? (~v_in + 1'b1) : v_in;

	always_comb begin
		if (radix < RADIX_MIN) begin
			radix_cl = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			radix_cl = RADIX_MAX;
		end else begin
			radix_cl = radix;
		end
	end

	// restoring division of the top byte, remainder carried between bytes
	always_comb begin
		logic [DIV_STEP-1:0] top;
		logic [4:0]          part;
		logic [4:0]          diff;
		logic [3:0]          r;
		top    = mag_q[MAG_W-1 -: DIV_STEP];
		r      = rem_q;
		q_bits = '0;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			part = {r, top[i]};
			diff = part - radix_q;
			if (part >= radix_q) begin
				q_bits[i] = 1'b1;
				r         = diff[3:0];
			end else begin
				r = part[3:0];
			end
		end
		rem_next = r;
	end

	assign rd_addr = ADDR_W'(count_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.load) begin
				mag_q   <= MAG_W'(v_mag);
				count_q <= '0;
			end else if (cmd.div) begin
				mag_q <= (mag_q << DIV_STEP) | MAG_W'(q_bits);
				if (cmd.wr_digit) begin
					count_q <= count_q + 1'b1;
				end
			end else if (cmd.emit) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q   <= '0;
			radix_q <= radix_cl;
			lower_q <= lowercase;
			neg_q   <= v_neg;
		end else if (cmd.div) begin
			rem_q <= cmd.wr_digit ? 4'd0 : rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div && cmd.wr_digit) begin
			digit_store_q[count_q[ADDR_W-1:0]] <= rem_next;
		end
		if (cmd.rd) begin
			rd_q <= digit_store_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			digit_char <= digit_ascii(rd_q, lower_q);
			negative   <= neg_q;
			last_digit <= sts.last_one;
		end
	end

	assign sts.quot_zero  = (mag_q == '0);
	assign sts.store_full = (count_q == CNT_W'(STORE_DEPTH));
	assign sts.last_one   = (count_q == CNT_W'(1));

endmodule

`default_nettype wire

// ===== design/ritoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ritoa_ctrl
// controller: sequences division byte steps, digit checks and character output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "radix_integer_to_ascii_core_macros.svh"

module ritoa_ctrl
	import ritoa_pkg::*;
#(
	parameter int CHUNKS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire ritoa_sts_t sts,
	output ritoa_cmd_t      cmd
);

	localparam int CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_LD    = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [CW-1:0] chunk_q;
	logic [CW-1:0] chunk_d;
	logic          out_valid_q;
	logic          out_free;
	logic          chunk_last;

	assign out_free   = !out_valid_q || out_ready;
	assign chunk_last = (chunk_q == CW'(CHUNKS - 1));
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		chunk_d = chunk_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					chunk_d  = '0;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (chunk_last) begin
					cmd.wr_digit = 1'b1;
					state_d      = ST_CHECK;
				end else begin
					chunk_d = chunk_q + 1'b1;
				end
			end
			ST_CHECK: begin
				if (sts.quot_zero || sts.store_full) begin
					state_d = ST_RD;
				end else begin
					chunk_d = '0;
					state_d = ST_DIV;
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_LD;
			end
			ST_LD: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.last_one ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chunk_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chunk_q <= chunk_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`RITOA_ASSERT_IMP(a_idle_no_work, state_q == ST_IDLE, !cmd.div && !cmd.rd && !cmd.emit, "work command while idle")
	`RITOA_ASSERT_IMP(a_emit_free, cmd.emit, !out_valid_q || out_ready, "output register overwritten")
	`RITOA_ASSERT_NXT(a_last_to_idle, cmd.emit && sts.last_one, state_q == ST_IDLE, "no return to idle after last digit")
	`RITOA_ASSERT_NXT(a_emit_valid, cmd.emit, out_valid_q, "emitted digit not presented")

endmodule

`default_nettype wire

// ===== design/radix_integer_to_ascii_core.sv =====
// division: each digit takes CHUNKS (= ceil(VALUE_BITS/8)) byte steps, one byte of the
//   magnitude divided per cycle, then a check for a zero quotient or a full digit store
// output: per character, a registered digit store read, then an output load that
//   waits until the output register is free (out_valid low or out_ready high)
// one request at a time; in_ready is high only while the controller is idle
// reset: arst_n asynchronous active low clears controller state, counts and out_valid
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_core
// converts an integer to ascii digits in radix 2..16, most significant first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix_integer_to_ascii_core
	import ritoa_pkg::*;
#(
	parameter int VALUE_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] value,
	input  wire logic [4:0]  radix,
	input  wire logic        unsigned_mode,
	input  wire logic        lowercase,
	// character channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       digit_char,
	output logic             negative,
	output logic             last_digit
);

	// number of byte-wide division steps needed to cover the magnitude
	localparam int CHUNKS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;

	ritoa_cmd_t cmd;
	ritoa_sts_t sts;

	// controller: walks idle -> divide bytes -> check quotient -> read/emit digits
	ritoa_ctrl #(
		.CHUNKS (CHUNKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: sign handling, radix clamp, divider slice, digit store and
	// the output register that lets each character wait for the consumer
	ritoa_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.value         (value),
		.radix         (radix),
		.unsigned_mode (unsigned_mode),
		.lowercase     (lowercase),
		.digit_char    (digit_char),
		.negative      (negative),
		.last_digit    (last_digit)
	);

endmodule

`default_nettype wire

// ===== verif/tb_radix_integer_to_ascii_core.sv =====
// ----------------------------------------------------------------------------
// tb_radix_integer_to_ascii_core
// self-checking bench for the integer to ascii digit converter: a scoreboard
// predicts the digit string of each accepted request and checks every
// character that comes out, while both channels idle and stall at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_radix_integer_to_ascii_core;
	import ritoa_pkg::*;

	localparam int VALUE_BITS   = 64;
	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 480;
	// settle for longer than the slowest request takes
	localparam int SETTLE_CYCLES = 750;
	// receiver hold longer than the slowest request, so the request side backs up
	localparam int HOLD_CYCLES   = 1000;
	// watchdog limit in ns, with a wide margin over the slowest run
	localparam longint LIMIT_NS  = 64'd20_000_000;

	typedef struct packed {
		logic [63:0] value;
		logic [4:0]  radix;
		logic        unsigned_mode;
		logic        lowercase;
	} request_t;

	typedef struct {
		logic [7:0] digit_char;
		logic       negative;
		logic       last_digit;
	} char_t;

	// expected character stream and mismatch count
	class digit_scoreboard #(int WIDTH = 64);
		char_t expected_chars[$];
		int    errors;

		function new();
			errors = 0;
		endfunction

		task report(string what);
			$display("error: %s", what);
			errors++;
		endtask

		// spell out the digits of one accepted request, most significant first
		function void note_request(request_t rq);
			logic [63:0] mask;
			logic [63:0] mag;
			logic [63:0] base;
			logic        neg;
			logic [3:0]  digits[$];
			string       glyphs;
			char_t       c;
			mask = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
			mag  = rq.value & mask;
			base = {59'd0, rq.radix};
			if (base < RADIX_MIN)
				base = 64'(RADIX_MIN);
			if (base > RADIX_MAX)
				base = 64'(RADIX_MAX);
			// signed mode: negate into an unsigned magnitude, most negative included
			neg = !rq.unsigned_mode && mag[WIDTH-1];
			if (neg)
				mag = (~mag + 64'd1) & mask;
			do begin
				digits.push_front(4'(mag % base));
				mag = mag / base;
			end while (mag != 0);
			glyphs = rq.lowercase ? "0123456789abcdef" : "0123456789ABCDEF";
			foreach (digits[i]) begin
				c.digit_char = glyphs[digits[i]];
				c.negative   = neg;
				c.last_digit = (i == digits.size() - 1);
				expected_chars.push_back(c);
			end
		endfunction

		task check_char(logic [7:0] ch, logic neg, logic last);
			char_t e;
			if (expected_chars.size() == 0) begin
				report($sformatf("character %h with nothing expected", ch));
			end else begin
				e = expected_chars.pop_front();
				if (ch !== e.digit_char)
					report($sformatf("digit_char %h, expected %h", ch, e.digit_char));
				if (neg !== e.negative)
					report($sformatf("negative %b, expected %b", neg, e.negative));
				if (last !== e.last_digit)
					report($sformatf("last_digit %b, expected %b", last, e.last_digit));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] value;
	logic [4:0]  radix;
	logic        unsigned_mode;
	logic        lowercase;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  digit_char;
	logic        negative;
	logic        last_digit;

	// both sides run without gaps while set
	bit no_idle;
	// sender asks the receiver for one long hold-off
	bit hold_output;

	digit_scoreboard #(VALUE_BITS) sb;

	radix_integer_to_ascii_core #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.radix        (radix),
		.unsigned_mode(unsigned_mode),
		.lowercase    (lowercase),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digit_char   (digit_char),
		.negative     (negative),
		.last_digit   (last_digit)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 12);
	endfunction

	// offer one request and wait until it is taken; in_valid only drops on a gap
	task automatic send_request(request_t rq);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		value         <= rq.value;
		radix         <= rq.radix;
		unsigned_mode <= rq.unsigned_mode;
		lowercase     <= rq.lowercase;
		// handshake is seen with pre-edge values, so no race with the block
		do @(posedge clk); while (!in_ready);
		sb.note_request(rq);
	endtask

	task automatic send_fields(logic [63:0] v, logic [4:0] r, logic u, logic l);
		request_t rq;
		rq = '{value: v, radix: r, unsigned_mode: u, lowercase: l};
		send_request(rq);
	endtask

	// mostly legal radixes, magnitudes spread from a few digits to the full width
	function automatic request_t random_request();
		request_t    rq;
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: ;
			1: v = v >> $urandom_range(0, 63);
			2: v = -(v >> $urandom_range(0, 63));
			default: v = 64'($urandom_range(0, 20));
		endcase
		rq.value         = v;
		rq.radix         = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(2, 16))
		                                              : 5'($urandom_range(0, 31));
		rq.unsigned_mode = 1'($urandom_range(0, 1));
		rq.lowercase     = 1'($urandom_range(0, 1));
		return rq;
	endfunction

	// character side: random ready gaps, one long hold when asked
	initial begin : drain
		int gap;
		bit held;
		held      = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_output && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = draw_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_char(digit_char, negative, last_digit);
		end
	end

	// request side: reset, directed corners, then random requests
	initial begin : stimulus
		sb            = new();
		no_idle       = 1'b0;
		hold_output   = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		value         = '0;
		radix         = '0;
		unsigned_mode = 1'b0;
		lowercase     = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero in both modes gives a lone '0' with no sign
		send_fields(64'd0, 5'd10, 1'b0, 1'b0);
		send_fields(64'd0, 5'd2, 1'b1, 1'b1);
		// longest string: 64 binary ones
		send_fields('1, 5'd2, 1'b1, 1'b0);
		// minus one in signed mode
		send_fields('1, 5'd10, 1'b0, 1'b0);
		// most negative value converts exactly
		send_fields(64'h8000_0000_0000_0000, 5'd2, 1'b0, 1'b0);
		send_fields(64'h8000_0000_0000_0000, 5'd16, 1'b1, 1'b0);
		send_fields(64'h7fff_ffff_ffff_ffff, 5'd10, 1'b0, 1'b1);
		send_fields('1, 5'd10, 1'b1, 1'b0);
		// letter case on every hex digit
		send_fields(64'hfedc_ba98_7654_3210, 5'd16, 1'b1, 1'b1);
		send_fields(64'hfedc_ba98_7654_3210, 5'd16, 1'b1, 1'b0);
		// radix below range clamps to binary, above range to hex
		send_fields(64'd12345, 5'd0, 1'b1, 1'b0);
		send_fields(64'd12345, 5'd1, 1'b0, 1'b0);
		send_fields(64'hdead_beef, 5'd17, 1'b1, 1'b0);
		send_fields(-64'd48879, 5'd31, 1'b0, 1'b1);
		// other radixes, all but 4 and 6
		send_fields('1, 5'd3, 1'b1, 1'b0);
		send_fields(-64'd1000, 5'd7, 1'b0, 1'b0);
		send_fields(64'h0123_4567_89ab_cdef, 5'd8, 1'b1, 1'b0);
		send_fields('1, 5'd15, 1'b1, 1'b1);
		send_fields(64'd1, 5'd9, 1'b0, 1'b0);
		send_fields(64'hf, 5'd16, 1'b0, 1'b0);
		send_fields(-64'd12345, 5'd11, 1'b0, 1'b1);
		send_fields('1, 5'd12, 1'b1, 1'b0);
		send_fields(64'h1234_5678_9abc_def0, 5'd13, 1'b0, 1'b1);
		send_fields(64'hcafe_f00d_0bad_1dea, 5'd14, 1'b0, 1'b0);
		send_fields(64'h5555_5555_5555_5555, 5'd5, 1'b1, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// alternate stretches of random gaps and back-to-back traffic
			if (i % 80 == 79)
				no_idle = ~no_idle;
			if (i == 100)
				hold_output = 1'b1;
			send_request(random_request());
		end
		in_valid <= 1'b0;

		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog against a hung handshake
	initial begin : watchdog
		#(LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
